[hdl/cramer_3x3_solver_defines.svh]
// ---------------------------------------------------------------------------
// cramer_3x3_solver_defines
// Assertion macros for the 3x3 Cramer solver; empty in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef CRAMER_3X3_SOLVER_DEFINES_SVH
`define CRAMER_3X3_SOLVER_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge outside reset
`define C3S_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition never holds
`define C3S_ASSERT_NEVER(label, cond, msg) \
    `C3S_ASSERT(label, !(cond), msg)
`else
`define C3S_ASSERT(label, prop, msg)
`define C3S_ASSERT_NEVER(label, cond, msg)
`endif

`endif

[hdl/c3s_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// c3s_pkg
// Widths, types and the Sarrus term table for the 3x3 Cramer solver.
// ---------------------------------------------------------------------------
package c3s_pkg;

    localparam int COEF_W = 16;
    localparam int PROD_W = 2 * COEF_W;
    localparam int TRIP_W = 3 * COEF_W;
    localparam int SUM_W  = TRIP_W + 3;
    localparam int DET_W  = ((3 * COEF_W + 1) > 63) ? 63 : (3 * COEF_W + 1);
    localparam int IN_W   = ((12 * COEF_W + 7) / 8) * 8;
    localparam int OUT_W  = ((7 * DET_W + 7) / 8) * 8;
    localparam int NUM_DET  = 4;
    localparam int NUM_TERM = 6;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [TRIP_W-1:0] trip_t;
    typedef logic [DET_W-1:0] det_t;

    // Column used in each row for each Sarrus term; first three add, last three subtract
    localparam logic [1:0] TERM_COL [NUM_TERM][3] = '{
        '{2'd0, 2'd1, 2'd2},
        '{2'd1, 2'd2, 2'd0},
        '{2'd2, 2'd0, 2'd1},
        '{2'd2, 2'd1, 2'd0},
        '{2'd1, 2'd0, 2'd2},
        '{2'd0, 2'd2, 2'd1}
    };

    // One stage of the three parallel restoring dividers
    typedef struct packed {
        det_t [NUM_DET-1:0] det;
        det_t               dmag;
        logic [2:0]         qneg;
        det_t [2:0]         rem;
        det_t [2:0]         nq;
        logic               sing;
    } div_stage_t;

endpackage

[hdl/cramer_3x3_solver.sv]
`timescale 1ns / 1ps
// Throughput: one system per cycle unless the output beat stalls; the 49 divide
// stages retire one quotient bit each. The whole pipeline advances together and
// holds while the output beat waits.
// Reset (rst_n low, asynchronous) clears every valid bit; data registers keep no reset.
// ---------------------------------------------------------------------------
// cramer_3x3_solver
// Solves a 3x3 integer system by Cramer's rule: Sarrus determinants in three
// stages, then pipelined truncating division of each column determinant.
// ---------------------------------------------------------------------------
`include "cramer_3x3_solver_defines.svh"

module cramer_3x3_solver (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // a11 a12 a13 a21 a22 a23 a31 a32 a33 b1 b2 b3, from bit 0 up
    input  logic [c3s_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // main_det det_x det_y det_z x_value y_value z_value, from bit 0 up, zero pad
    output logic [c3s_pkg::OUT_W-1:0]  m_axis_tdata,
    // singular
    output logic [0:0]                 m_axis_tuser
);

    localparam int DW = c3s_pkg::DET_W;
    localparam int ND = c3s_pkg::NUM_DET;
    localparam int NT = c3s_pkg::NUM_TERM;

    logic en;

    c3s_pkg::coef_t mat [ND][3][3];

    c3s_pkg::prod_t pp_reg [ND][NT];
    c3s_pkg::prod_t pp_next [ND][NT];
    c3s_pkg::coef_t tf_reg [ND][NT];
    c3s_pkg::coef_t tf_next [ND][NT];
    logic           v1_reg;

    c3s_pkg::trip_t tp_reg [ND][NT];
    c3s_pkg::trip_t tp_next [ND][NT];
    logic           v2_reg;

    c3s_pkg::det_t  det_reg [ND];
    c3s_pkg::det_t  det_next [ND];
    logic           v3_reg;

    c3s_pkg::div_stage_t ds_reg [DW+1];
    c3s_pkg::div_stage_t ds_next [DW+1];
    logic [DW:0]         dv_reg;

    c3s_pkg::det_t  q_next [3];
    logic [c3s_pkg::OUT_W-1:0] out_reg;
    logic [c3s_pkg::OUT_W-1:0] out_next;
    logic           sing_reg;
    logic           out_valid_reg;

    // Advance everything unless the output beat is stalled
    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    // Build the four matrices: main, then column k replaced by b
    always_comb
    begin
        for (int d = 0; d < ND; d++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    if (d != 0 && c == d - 1)
                        mat[d][r][c] = s_axis_tdata[(9 + r) * c3s_pkg::COEF_W
                                                    +: c3s_pkg::COEF_W];
                    else
                        mat[d][r][c] = s_axis_tdata[(r * 3 + c) * c3s_pkg::COEF_W
                                                    +: c3s_pkg::COEF_W];
                end
            end
        end
    end

    // Stage 1: pair products of rows 1 and 2, hold the row 3 factor
    always_comb
    begin
        for (int d = 0; d < ND; d++)
        begin
            for (int t = 0; t < NT; t++)
            begin
                pp_next[d][t] = mat[d][0][c3s_pkg::TERM_COL[t][0]]
                              * mat[d][1][c3s_pkg::TERM_COL[t][1]];
                tf_next[d][t] = mat[d][2][c3s_pkg::TERM_COL[t][2]];
            end
        end
    end

    // Stage 2: triple products, formed at full triple width
    always_comb
    begin
        for (int d = 0; d < ND; d++)
        begin
            for (int t = 0; t < NT; t++)
            begin
                tp_next[d][t] = pp_reg[d][t] * tf_reg[d][t];
            end
        end
    end

    // Stage 3: Sarrus sums, kept modulo 2^DET_W
    always_comb
    begin
        logic signed [c3s_pkg::SUM_W-1:0] acc;
        for (int d = 0; d < ND; d++)
        begin
            acc = '0;
            for (int t = 0; t < NT; t++)
            begin
                if (t < 3)
                    acc = acc + c3s_pkg::SUM_W'(tp_reg[d][t]);
                else
                    acc = acc - c3s_pkg::SUM_W'(tp_reg[d][t]);
            end
            det_next[d] = acc[DW-1:0];
        end
    end

    // Divider entry: magnitudes and quotient signs
    always_comb
    begin
        ds_next[0].det  = {det_reg[3], det_reg[2], det_reg[1], det_reg[0]};
        ds_next[0].dmag = det_reg[0][DW-1] ? DW'(-det_reg[0]) : det_reg[0];
        ds_next[0].sing = (det_reg[0] == '0);
        for (int k = 0; k < 3; k++)
        begin
            ds_next[0].qneg[k] = det_reg[k+1][DW-1] ^ det_reg[0][DW-1];
            ds_next[0].rem[k]  = '0;
            ds_next[0].nq[k]   = det_reg[k+1][DW-1] ? DW'(-det_reg[k+1]) : det_reg[k+1];
        end
    end

    // Divide stages: one quotient bit per stage for each column
    for (genvar s = 0; s < DW; s++)
    begin : g_div
        always_comb
        begin
            logic [DW:0] trial;
            logic        ge;
            ds_next[s+1] = ds_reg[s];
            for (int k = 0; k < 3; k++)
            begin
                trial = {ds_reg[s].rem[k], ds_reg[s].nq[k][DW-1]};
                ge    = (trial >= {1'b0, ds_reg[s].dmag});
                if (ge)
                    trial = trial - {1'b0, ds_reg[s].dmag};
                ds_next[s+1].rem[k] = trial[DW-1:0];
                ds_next[s+1].nq[k]  = {ds_reg[s].nq[k][DW-2:0], ge};
            end
        end
    end

    // Output: apply signs, zero the quotients of a singular system
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (ds_reg[DW].sing)
                q_next[k] = '0;
            else if (ds_reg[DW].qneg[k])
                q_next[k] = DW'(-ds_reg[DW].nq[k]);
            else
                q_next[k] = ds_reg[DW].nq[k];
        end
        out_next = c3s_pkg::OUT_W'({q_next[2], q_next[1], q_next[0], ds_reg[DW].det});
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            dv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= s_axis_tvalid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            dv_reg        <= {dv_reg[DW-1:0], v3_reg};
            out_valid_reg <= dv_reg[DW];
        end
    end

    // Data registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_reg   <= pp_next;
            tf_reg   <= tf_next;
            tp_reg   <= tp_next;
            det_reg  <= det_next;
            for (int s = 0; s <= DW; s++)
                ds_reg[s] <= ds_next[s];
            out_reg  <= out_next;
            sing_reg <= ds_reg[DW].sing;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;
    assign m_axis_tuser  = sing_reg;

    `C3S_ASSERT(a_sing_zero_q,
        m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tdata[7*DW-1:4*DW] == '0),
        "singular result with nonzero quotient")
    `C3S_ASSERT(a_sing_det,
        m_axis_tvalid |-> (m_axis_tuser[0] == (m_axis_tdata[DW-1:0] == '0)),
        "singular flag disagrees with main determinant")
    `C3S_ASSERT(a_unit_det,
        m_axis_tvalid && (m_axis_tdata[DW-1:0] == DW'(1))
            |-> (m_axis_tdata[5*DW-1:4*DW] == m_axis_tdata[2*DW-1:DW]),
        "unit determinant quotient differs from det_x")

endmodule

[tb/cramer_3x3_solver_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cramer_3x3_solver_tb
// Streams 3x3 integer systems into the Cramer solver and checks every result
// beat (four determinants, three quotients, singular flag) against a local
// predictor, under several idling patterns and a long output hold-off.
// ---------------------------------------------------------------------------
module cramer_3x3_solver_tb;

    localparam int LATENCY = c3s_pkg::DET_W + 4;
    localparam int DW      = c3s_pkg::DET_W;
    localparam int CW      = c3s_pkg::COEF_W;

    typedef logic signed [DW-1:0] sdet_t;

    typedef struct {
        c3s_pkg::det_t det  [4];
        c3s_pkg::det_t quot [3];
        logic          sing;
    } solution_t;

    logic                        clk;
    logic                        rst_n;
    logic                        s_axis_tvalid;
    logic                        s_axis_tready;
    logic [c3s_pkg::IN_W-1:0]    s_axis_tdata;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready;
    logic [c3s_pkg::OUT_W-1:0]   m_axis_tdata;
    logic [0:0]                  m_axis_tuser;

    solution_t           pending_solutions [$];
    int                  error_count;
    int                  send_idle_pct;
    int                  recv_stall_pct;
    int                  hold_off_cycles;

    cramer_3x3_solver dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Determinant by the rule of Sarrus, wrapped to DET_W bits
    function automatic c3s_pkg::det_t sarrus_det(input longint m [3][3]);
        longint pos;
        longint neg;
        begin
            pos = m[0][0] * m[1][1] * m[2][2] + m[0][1] * m[1][2] * m[2][0]
                + m[0][2] * m[1][0] * m[2][1];
            neg = m[0][2] * m[1][1] * m[2][0] + m[0][1] * m[1][0] * m[2][2]
                + m[0][0] * m[1][2] * m[2][1];
            sarrus_det = c3s_pkg::det_t'(pos - neg);
        end
    endfunction

    // Solve one system: coefficients row-major, then right-hand sides
    function automatic solution_t solve_system(input logic [c3s_pkg::IN_W-1:0] beat);
        longint    a   [3][3];
        longint    t   [3][3];
        longint    rhs [3];
        longint    num;
        longint    den;
        solution_t s;
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                    a[r][c] = longint'(c3s_pkg::coef_t'(beat[(r*3+c)*CW +: CW]));
                rhs[r] = longint'(c3s_pkg::coef_t'(beat[(9+r)*CW +: CW]));
            end
            s.det[0] = sarrus_det(a);
            for (int k = 0; k < 3; k++)
            begin
                t = a;
                for (int r = 0; r < 3; r++)
                    t[r][k] = rhs[r];
                s.det[k+1] = sarrus_det(t);
            end
            s.sing = (s.det[0] == '0);
            den = longint'(sdet_t'(s.det[0]));
            for (int k = 0; k < 3; k++)
            begin
                num = longint'(sdet_t'(s.det[k+1]));
                s.quot[k] = s.sing ? '0 : c3s_pkg::det_t'(num / den);
            end
            solve_system = s;
        end
    endfunction

    task automatic report_mismatch(input string what, input c3s_pkg::det_t got,
                                   input c3s_pkg::det_t want);
        begin
            $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
            error_count++;
        end
    endtask

    // Drive one system and wait for its beat to be taken; valid stays up after
    task automatic send_system(input logic [c3s_pkg::IN_W-1:0] beat);
        begin
            while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= beat;
            do
                @(posedge clk);
            while (!s_axis_tready);
            pending_solutions.push_back(solve_system(beat));
        end
    endtask

    function automatic logic [c3s_pkg::IN_W-1:0] pack_system(input c3s_pkg::coef_t f [12]);
        logic [c3s_pkg::IN_W-1:0] beat;
        begin
            beat = '0;
            for (int i = 0; i < 12; i++)
                beat[i*CW +: CW] = f[i];
            pack_system = beat;
        end
    endfunction

    function automatic c3s_pkg::coef_t random_coef();
        int sel;
        begin
            sel = $urandom_range(9);
            case (sel)
                0:       random_coef = c3s_pkg::coef_t'(16'sh8000);
                1:       random_coef = c3s_pkg::coef_t'(16'sh7fff);
                2:       random_coef = c3s_pkg::coef_t'($urandom_range(7))
                                     - c3s_pkg::coef_t'(3);
                3:       random_coef = '0;
                default: random_coef = c3s_pkg::coef_t'($urandom);
            endcase
        end
    endfunction

    // Drop valid and wait for every pending result
    task automatic wait_drained();
        begin
            s_axis_tvalid <= 1'b0;
            while (pending_solutions.size() != 0)
                @(posedge clk);
        end
    endtask

    // Receiver: random stalls plus an optional long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_axis_tready   <= 1'b0;
        end
        else
            m_axis_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end

    // Check each result beat against the oldest pending solution
    always @(posedge clk)
    begin
        solution_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_solutions.size() == 0)
            begin
                report_mismatch("unexpected beat", m_axis_tdata[DW-1:0], '0);
            end
            else
            begin
                want = pending_solutions.pop_front();
                for (int k = 0; k < 4; k++)
                    if (m_axis_tdata[k*DW +: DW] !== want.det[k])
                        report_mismatch($sformatf("det%0d", k),
                                        m_axis_tdata[k*DW +: DW], want.det[k]);
                for (int k = 0; k < 3; k++)
                    if (m_axis_tdata[(4+k)*DW +: DW] !== want.quot[k])
                        report_mismatch($sformatf("quotient%0d", k),
                                        m_axis_tdata[(4+k)*DW +: DW], want.quot[k]);
                if (m_axis_tuser[0] !== want.sing)
                    report_mismatch("singular", c3s_pkg::det_t'(m_axis_tuser),
                                    c3s_pkg::det_t'(want.sing));
            end
        end
    end

    // Directed systems: extremes, singular, identity, sign mixes, then twelve random systems
    task automatic test_directed();
        c3s_pkg::coef_t f [12];
        begin
            foreach (f[i]) f[i] = c3s_pkg::coef_t'(16'sh8000);
            send_system(pack_system(f));
            foreach (f[i]) f[i] = c3s_pkg::coef_t'(16'sh7fff);
            send_system(pack_system(f));
            foreach (f[i]) f[i] = '0;
            send_system(pack_system(f));
            // identity with varied right-hand sides
            f[0] = c3s_pkg::coef_t'(1); f[4] = c3s_pkg::coef_t'(1); f[8] = c3s_pkg::coef_t'(1);
            f[9] = c3s_pkg::coef_t'(16'sh8000); f[10] = c3s_pkg::coef_t'(16'sh7fff);
            f[11] = c3s_pkg::coef_t'(-5);
            send_system(pack_system(f));
            // diagonal of mixed signs, quotients truncate toward zero
            f[0] = c3s_pkg::coef_t'(-3); f[4] = c3s_pkg::coef_t'(3); f[8] = c3s_pkg::coef_t'(-3);
            f[9] = c3s_pkg::coef_t'(7); f[10] = c3s_pkg::coef_t'(-7); f[11] = c3s_pkg::coef_t'(8);
            send_system(pack_system(f));
            // maximum magnitude diagonal with minimum values
            foreach (f[i]) f[i] = '0;
            f[0] = c3s_pkg::coef_t'(16'sh8000); f[4] = c3s_pkg::coef_t'(16'sh8000);
            f[8] = c3s_pkg::coef_t'(16'sh8000);
            f[1] = c3s_pkg::coef_t'(16'sh7fff); f[9] = c3s_pkg::coef_t'(16'sh7fff);
            f[10] = c3s_pkg::coef_t'(1); f[11] = c3s_pkg::coef_t'(-1);
            send_system(pack_system(f));
            f[4] = c3s_pkg::coef_t'(16'sh7fff); f[5] = c3s_pkg::coef_t'(16'sh8000);
            send_system(pack_system(f));
            // alternating bit patterns
            foreach (f[i])
                f[i] = (i % 2) ? c3s_pkg::coef_t'(16'h5555) : c3s_pkg::coef_t'(16'haaaa);
            send_system(pack_system(f));
            // singular: two equal rows
            foreach (f[i]) f[i] = c3s_pkg::coef_t'(i + 1);
            f[3] = c3s_pkg::coef_t'(1); f[4] = c3s_pkg::coef_t'(2); f[5] = c3s_pkg::coef_t'(3);
            send_system(pack_system(f));
            for (int n = 0; n < 12; n++)
            begin
                foreach (f[i]) f[i] = random_coef();
                send_system(pack_system(f));
            end
            wait_drained();
        end
    endtask

    // Random systems; a share made singular by repeating a row
    task automatic test_random(input int count);
        c3s_pkg::coef_t f [12];
        begin
            for (int n = 0; n < count; n++)
            begin
                foreach (f[i]) f[i] = random_coef();
                if ($urandom_range(9) == 0)
                    for (int c = 0; c < 3; c++)
                        f[3 + c] = f[c];
                send_system(pack_system(f));
            end
        end
    endtask

    // Hold the output for a long stretch while input keeps arriving
    task automatic test_backpressure();
        begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
            hold_off_cycles = 4 * LATENCY;
            test_random(2 * LATENCY);
            wait_drained();
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        error_count   = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(110);
        send_idle_pct = 50;
        test_random(100);
        send_idle_pct  = 0;
        recv_stall_pct = 50;
        test_random(100);
        send_idle_pct  = 31;
        recv_stall_pct = 31;
        test_random(100);
        wait_drained();
        test_backpressure();

        wait_drained();
        repeat (LATENCY + 10) @(posedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Timeout
    initial
    begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
